// File: design/mpts_pkg.sv
package mpts_pkg;

  localparam int MaxTasks = 16;
  localparam int SlotW = $clog2(MaxTasks);
  localparam int CntW = $clog2(MaxTasks + 1);
  localparam int MaxCpus = 8;
  localparam int CpuW = $clog2(MaxCpus);
  localparam int CpuCntW = $clog2(MaxCpus + 1);
  localparam int TimeW = 16;
  localparam int DoneMax = 31;

  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam logic [15:0] PrioMax = 16'hFFFF;
  localparam logic [15:0] LfsrSeed = 16'hACE1;
  localparam logic [15:0] LfsrMask = 16'hB400;

  localparam logic [1:0] PhNew = 2'd0;
  localparam logic [1:0] PhReady = 2'd1;
  localparam logic [1:0] PhRun = 2'd2;
  localparam logic [1:0] PhDone = 2'd3;

  localparam logic [1:0] ModeAging = 2'd1;
  localparam logic [1:0] ModeSrtf = 2'd2;

  localparam logic [2:0] CfgMode = 3'd0;
  localparam logic [2:0] CfgSlice = 3'd1;
  localparam logic [2:0] CfgCpus = 3'd2;
  localparam logic [2:0] CfgAging = 3'd3;
  localparam logic [2:0] CfgTasks = 3'd4;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncTick = 1'b1;

  typedef struct packed {
    logic [7:0] ident;
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] burst;
    logic [TimeW-1:0] remaining;
    logic [7:0] sprio;
    logic [15:0] dprio;
    logic [TimeW-1:0] slice_used;
  } task_rec_t;

endpackage

// File: design/mpts_if.sv
interface mpts_in_if;
  import mpts_pkg::*;
  logic valid;
  logic ready;
  logic func;
  logic [3:0] slot;
  logic [7:0] task_number;
  logic [15:0] arrival_time;
  logic [15:0] burst_length;
  logic [7:0] base_prio;
  modport source (output valid, func, slot, task_number, arrival_time, burst_length,
                  base_prio, input ready);
  modport sink (input valid, func, slot, task_number, arrival_time, burst_length,
                base_prio, output ready);
endinterface

interface mpts_out_if;
  logic valid;
  logic ready;
  logic [2:0] cpu_index;
  logic cpu_busy;
  logic [3:0] task_slot;
  logic [15:0] task_left;
  logic [15:0] tick_number;
  logic [15:0] idle_ticks;
  logic [4:0] finished_count;
  logic all_done;
  logic coin_used;
  logic last;
  modport source (output valid, cpu_index, cpu_busy, task_slot, task_left, tick_number,
                  idle_ticks, finished_count, all_done, coin_used, last, input ready);
  modport sink (input valid, cpu_index, cpu_busy, task_slot, task_left, tick_number,
                idle_ticks, finished_count, all_done, coin_used, last, output ready);
endinterface

interface mpts_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/multicore_preemptive_task_scheduler.sv
// Channel     Dir  Word
// task_in     in   load entry (func 0) or tick (func 1)
// result_out  out  one word per processor in use, after each tick
// cfg         in   register index and data, always ready
//
// A load is written in the idle state. A tick runs the processor check, admission and
// requeue, then the pick passes, with a search for a processor to preempt when a pass
// finds no place for its pick, then the run step, aging in aging mode and retire, all
// paced by the task memory. Reset is synchronous and clears the state, settings,
// counters, phases, processor holds and ready queue; the task memory is not cleared.
// The block works on one word at a time and holds each result until it is taken.
module multicore_preemptive_task_scheduler
  import mpts_pkg::*;
(
  input logic clk,
  input logic rst,
  mpts_in_if.sink task_in,
  mpts_out_if.source result_out,
  mpts_cfg_if.sink cfg
);

  typedef enum logic [4:0] {
    S_IDLE, S_SHRINK, S_CHECK, S_ADMIT_RD, S_ADMIT_EV, S_HELD, S_P_START, S_P_WAIT0,
    S_P_RD, S_P_CMP, S_P_PLACE, S_W_RD, S_W_CMP, S_W_DEC, S_EVICT, S_RUN_RD, S_RUN_EV,
    S_AGE_RD, S_AGE_EV, S_RST_RD, S_RST_EV, S_RETIRE, S_OUT
  } state_t;

  state_t state;

  logic [1:0] sched_mode;
  logic [15:0] slice_len;
  logic [3:0] cpu_count;
  logic [7:0] aging_step;
  logic [4:0] task_count;

  task_rec_t mem [MaxTasks];
  task_rec_t rd;
  logic rd_en, we;
  logic [SlotW-1:0] rd_addr, wr_addr;
  task_rec_t wd;

  logic [1:0] phase [MaxTasks];
  logic [SlotW-1:0] ready_order [MaxTasks];
  logic [CntW-1:0] ready_count;
  logic cpu_held [MaxCpus];
  logic [SlotW-1:0] cpu_slot [MaxCpus];
  logic [TimeW-1:0] tick_count, idle_count, tnum;
  logic [4:0] done_count;
  logic [15:0] coin_lfsr;
  logic coin_task [MaxTasks];
  logic ran [MaxCpus];
  logic expire [MaxCpus];
  logic [SlotW-1:0] ran_slot [MaxCpus];
  logic [TimeW-1:0] ran_left [MaxCpus];

  logic [CntW-1:0] ci, j;
  logic [SlotW-1:0] best_i, b_slot, ev_slot;
  task_rec_t best;
  logic by_coin, idle_res;
  logic [15:0] lim;
  logic worst_ok;
  logic [CpuW-1:0] worst;
  logic [CpuW-1:0] oi;

  logic [CntW-1:0] n_use;
  logic [CpuCntW-1:0] m_use;
  logic srtf, aging;

  always_comb begin
    n_use = (task_count > CntW'(MaxTasks)) ? CntW'(MaxTasks) : task_count;
    if (cpu_count == 4'd0) m_use = CpuCntW'(1);
    else if (cpu_count > 4'(MaxCpus)) m_use = CpuCntW'(MaxCpus);
    else m_use = CpuCntW'(cpu_count);
    srtf = (sched_mode == ModeSrtf);
    aging = (sched_mode == ModeAging);
  end

  logic empty;
  always_comb begin
    empty = 1'b1;
    for (int i = 0; i < MaxCpus; i++)
      if (CpuCntW'(i) < m_use && cpu_held[i]) empty = 1'b0;
  end

  logic q_push_en, q_rm_en, push_has, load_hit;
  logic [SlotW-1:0] q_push_slot, q_rm_idx, load_idx;
  always_comb begin
    push_has = 1'b0;
    load_hit = 1'b0;
    load_idx = '0;
    for (int k = MaxTasks - 1; k >= 0; k--) begin
      if (CntW'(k) < ready_count && ready_order[k] == q_push_slot) push_has = 1'b1;
      if (CntW'(k) < ready_count && ready_order[k] == task_in.slot) begin
        load_hit = 1'b1;
        load_idx = SlotW'(k);
      end
    end
  end

  logic [SlotW-1:0] cur_b;
  logic on_cpu, placed, place_free;
  logic [CpuW-1:0] place_i;
  always_comb begin
    cur_b = ready_order[best_i];
    on_cpu = 1'b0;
    placed = 1'b0;
    place_free = 1'b0;
    place_i = '0;
    for (int i = 0; i < MaxCpus; i++)
      if (CpuCntW'(i) < m_use && cpu_held[i] && cpu_slot[i] == cur_b) on_cpu = 1'b1;
    for (int i = MaxCpus - 1; i >= 0; i--) begin
      if (CpuCntW'(i) < m_use && (!cpu_held[i] || cpu_slot[i] == cur_b)) begin
        placed = 1'b1;
        place_free = !cpu_held[i];
        place_i = CpuW'(i);
      end
    end
  end

  logic c_swap, c_draw, c_coin;
  logic [15:0] ckey, bkey;
  always_comb begin
    logic tie, ce, be;
    ckey = srtf ? rd.remaining : rd.dprio;
    bkey = srtf ? best.remaining : best.dprio;
    c_swap = 1'b0;
    c_draw = 1'b0;
    c_coin = 1'b0;
    tie = (ckey == bkey);
    if (srtf ? (ckey < bkey) : (ckey > bkey)) c_swap = 1'b1;
    ce = phase[ready_order[j[SlotW-1:0]]] == PhRun;
    be = phase[ready_order[best_i]] == PhRun;
    if (tie) begin
      if (ce && !be) c_swap = 1'b1;
      if (ce || be) tie = 1'b0;
    end
    if (tie) begin
      if (rd.arrival < best.arrival) c_swap = 1'b1;
      else if (rd.arrival == best.arrival) begin
        if (rd.burst < best.burst) c_swap = 1'b1;
        else if (rd.burst == best.burst) begin
          c_draw = 1'b1;
          if (coin_lfsr[0]) begin
            c_swap = 1'b1;
            c_coin = 1'b1;
          end
        end
      end
    end
  end

  task_rec_t run_rec;
  logic run_exp;
  logic [16:0] aged;
  always_comb begin
    run_rec = rd;
    if (rd.remaining != '0) begin
      run_rec.remaining = rd.remaining - TimeW'(1);
      if (rd.slice_used != TimeMax) run_rec.slice_used = rd.slice_used + TimeW'(1);
    end
    run_exp = (slice_len != 16'd0) && (run_rec.slice_used >= slice_len) &&
              (run_rec.remaining != '0);
    if (run_exp) run_rec.slice_used = '0;
    aged = {1'b0, rd.dprio} + 17'(aging_step);
  end

  logic [CpuW-1:0] cc;
  logic [SlotW-1:0] cs;
  assign cc = ci[CpuW-1:0];
  assign cs = ci[SlotW-1:0];

  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    we = 1'b0;
    wr_addr = '0;
    wd = rd;
    q_push_en = 1'b0;
    q_push_slot = '0;
    q_rm_en = 1'b0;
    q_rm_idx = '0;
    unique case (state)
      S_IDLE: begin
        if (task_in.valid && task_in.func == FuncLoad) begin
          we = 1'b1;
          wr_addr = task_in.slot;
          wd.ident = task_in.task_number;
          wd.arrival = task_in.arrival_time;
          wd.burst = task_in.burst_length;
          wd.remaining = task_in.burst_length;
          wd.sprio = task_in.base_prio;
          wd.dprio = 16'(task_in.base_prio);
          wd.slice_used = '0;
          q_rm_en = load_hit;
          q_rm_idx = load_idx;
        end
      end
      S_SHRINK: begin
        q_push_slot = cpu_slot[cc];
        q_push_en = (CpuCntW'(cc) >= m_use) && cpu_held[cc];
      end
      S_ADMIT_RD: begin
        rd_en = 1'b1;
        rd_addr = cs;
      end
      S_ADMIT_EV: begin
        q_push_slot = cs;
        q_push_en = (phase[cs] == PhNew) && (rd.arrival == tick_count);
      end
      S_HELD: begin
        q_push_slot = cpu_slot[cc];
        q_push_en = cpu_held[cc];
      end
      S_P_START: begin
        rd_en = 1'b1;
        rd_addr = ready_order[0];
      end
      S_P_RD: begin
        rd_en = 1'b1;
        rd_addr = ready_order[j[SlotW-1:0]];
      end
      S_P_PLACE: begin
        q_rm_en = placed;
        q_rm_idx = best_i;
      end
      S_W_RD: begin
        rd_en = 1'b1;
        rd_addr = cpu_slot[cc];
      end
      S_W_DEC: begin
        q_rm_en = worst_ok;
        q_rm_idx = best_i;
      end
      S_EVICT: begin
        q_push_en = 1'b1;
        q_push_slot = ev_slot;
      end
      S_RUN_RD, S_RST_RD: begin
        rd_en = 1'b1;
        rd_addr = cpu_slot[cc];
      end
      S_RUN_EV: begin
        we = cpu_held[cc];
        wr_addr = cpu_slot[cc];
        wd = run_rec;
      end
      S_AGE_RD: begin
        rd_en = 1'b1;
        rd_addr = ready_order[cs];
      end
      S_AGE_EV: begin
        we = 1'b1;
        wr_addr = ready_order[cs];
        wd.dprio = aged[16] ? PrioMax : aged[15:0];
      end
      S_RST_EV: begin
        we = cpu_held[cc];
        wr_addr = cpu_slot[cc];
        wd.dprio = 16'(rd.sprio);
      end
      S_RETIRE: begin
        q_push_slot = cpu_slot[cc];
        q_push_en = cpu_held[cc] && ran_left[cc] != '0 && expire[cc];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wd;
    if (rd_en) rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sched_mode <= '0;
      slice_len <= '0;
      cpu_count <= 4'd1;
      aging_step <= '0;
      task_count <= '0;
      ready_count <= '0;
      tick_count <= '0;
      idle_count <= '0;
      done_count <= '0;
      coin_lfsr <= LfsrSeed;
      ci <= '0;
      j <= '0;
      oi <= '0;
      idle_res <= 1'b0;
      for (int k = 0; k < MaxTasks; k++) phase[k] <= PhNew;
      for (int i = 0; i < MaxCpus; i++) cpu_held[i] <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CfgMode: sched_mode <= cfg.data[1:0];
          CfgSlice: slice_len <= cfg.data;
          CfgCpus: cpu_count <= cfg.data[3:0];
          CfgAging: aging_step <= cfg.data[7:0];
          CfgTasks: task_count <= cfg.data[4:0];
          default: ;
        endcase
      end

      if (q_rm_en) begin
        for (int k = 0; k < MaxTasks - 1; k++)
          if (SlotW'(k) >= q_rm_idx) ready_order[k] <= ready_order[k+1];
        ready_count <= ready_count - CntW'(1);
      end else if (q_push_en && !push_has && ready_count < CntW'(MaxTasks)) begin
        ready_order[ready_count[SlotW-1:0]] <= q_push_slot;
        ready_count <= ready_count + CntW'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (task_in.valid) begin
            if (task_in.func == FuncLoad) begin
              for (int i = 0; i < MaxCpus; i++)
                if (cpu_held[i] && cpu_slot[i] == task_in.slot) cpu_held[i] <= 1'b0;
              phase[task_in.slot] <= PhNew;
            end else begin
              ci <= '0;
              state <= S_SHRINK;
            end
          end
        end
        S_SHRINK: begin
          if (q_push_en) begin
            phase[cpu_slot[cc]] <= PhReady;
            cpu_held[cc] <= 1'b0;
          end
          ci <= ci + CntW'(1);
          if (cc == CpuW'(MaxCpus - 1)) state <= S_CHECK;
        end
        S_CHECK: begin
          tnum <= tick_count;
          oi <= '0;
          ci <= '0;
          if (done_count >= 5'(n_use) && empty) begin
            idle_res <= 1'b1;
            state <= S_OUT;
          end else begin
            idle_res <= 1'b0;
            for (int k = 0; k < MaxTasks; k++) coin_task[k] <= 1'b0;
            state <= (n_use == '0) ? S_HELD : S_ADMIT_RD;
          end
        end
        S_ADMIT_RD: state <= S_ADMIT_EV;
        S_ADMIT_EV: begin
          if (q_push_en) phase[cs] <= PhReady;
          if (ci + CntW'(1) == n_use) begin
            ci <= '0;
            state <= S_HELD;
          end else begin
            ci <= ci + CntW'(1);
            state <= S_ADMIT_RD;
          end
        end
        S_HELD: begin
          ci <= ci + CntW'(1);
          if (ci + CntW'(1) == CntW'(m_use)) state <= S_P_START;
        end
        S_P_START: begin
          best_i <= '0;
          by_coin <= 1'b0;
          j <= CntW'(1);
          ci <= '0;
          state <= (ready_count == '0) ? S_RUN_RD : S_P_WAIT0;
        end
        S_P_WAIT0: begin
          best <= rd;
          state <= (ready_count > CntW'(1)) ? S_P_RD : S_P_PLACE;
        end
        S_P_RD: state <= S_P_CMP;
        S_P_CMP: begin
          if (c_draw)
            coin_lfsr <= (coin_lfsr >> 1) ^ (coin_lfsr[0] ? LfsrMask : 16'd0);
          if (c_swap) begin
            best_i <= j[SlotW-1:0];
            best <= rd;
            by_coin <= c_coin;
          end
          j <= j + CntW'(1);
          state <= (j + CntW'(1) < ready_count) ? S_P_RD : S_P_PLACE;
        end
        S_P_PLACE: begin
          if (by_coin) coin_task[cur_b] <= 1'b1;
          b_slot <= cur_b;
          if (placed) begin
            if (place_free && !on_cpu) begin
              cpu_held[place_i] <= 1'b1;
              cpu_slot[place_i] <= cur_b;
              phase[cur_b] <= PhRun;
            end
            state <= S_P_START;
          end else begin
            lim <= bkey;
            worst_ok <= 1'b0;
            ci <= '0;
            state <= S_W_RD;
          end
        end
        S_W_RD: state <= S_W_CMP;
        S_W_CMP: begin
          if (cpu_held[cc] &&
              (srtf ? (rd.remaining > lim) : (rd.dprio < lim))) begin
            lim <= srtf ? rd.remaining : rd.dprio;
            worst <= cc;
            worst_ok <= 1'b1;
          end
          ci <= ci + CntW'(1);
          state <= (ci + CntW'(1) == CntW'(m_use)) ? S_W_DEC : S_W_RD;
        end
        S_W_DEC: begin
          ci <= '0;
          if (worst_ok) begin
            ev_slot <= cpu_slot[worst];
            phase[cpu_slot[worst]] <= PhReady;
            cpu_slot[worst] <= b_slot;
            phase[b_slot] <= PhRun;
            state <= S_EVICT;
          end else state <= S_RUN_RD;
        end
        S_EVICT: state <= S_P_START;
        S_RUN_RD: state <= S_RUN_EV;
        S_RUN_EV: begin
          ran[cc] <= cpu_held[cc];
          expire[cc] <= cpu_held[cc] && run_exp;
          if (cpu_held[cc]) begin
            ran_slot[cc] <= cpu_slot[cc];
            ran_left[cc] <= run_rec.remaining;
          end else begin
            ran_slot[cc] <= '0;
            ran_left[cc] <= '0;
            if (done_count < 5'(n_use) && idle_count != TimeMax)
              idle_count <= idle_count + TimeW'(1);
          end
          if (ci + CntW'(1) == CntW'(m_use)) begin
            ci <= '0;
            if (!aging) state <= S_RETIRE;
            else if (ready_count != '0) state <= S_AGE_RD;
            else state <= S_RST_RD;
          end else begin
            ci <= ci + CntW'(1);
            state <= S_RUN_RD;
          end
        end
        S_AGE_RD: state <= S_AGE_EV;
        S_AGE_EV: begin
          if (ci + CntW'(1) == ready_count) begin
            ci <= '0;
            state <= S_RST_RD;
          end else begin
            ci <= ci + CntW'(1);
            state <= S_AGE_RD;
          end
        end
        S_RST_RD: state <= S_RST_EV;
        S_RST_EV: begin
          if (ci + CntW'(1) == CntW'(m_use)) begin
            ci <= '0;
            state <= S_RETIRE;
          end else begin
            ci <= ci + CntW'(1);
            state <= S_RST_RD;
          end
        end
        S_RETIRE: begin
          if (cpu_held[cc]) begin
            if (ran_left[cc] == '0) begin
              if (phase[cpu_slot[cc]] != PhDone && done_count != 5'(DoneMax))
                done_count <= done_count + 5'd1;
              phase[cpu_slot[cc]] <= PhDone;
              cpu_held[cc] <= 1'b0;
            end else if (expire[cc]) begin
              phase[cpu_slot[cc]] <= PhReady;
              cpu_held[cc] <= 1'b0;
            end
          end
          ci <= ci + CntW'(1);
          if (ci + CntW'(1) == CntW'(m_use)) begin
            if (tick_count != TimeMax) tick_count <= tick_count + TimeW'(1);
            oi <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (result_out.ready) begin
            if (CpuCntW'(oi) + CpuCntW'(1) == m_use) state <= S_IDLE;
            else oi <= oi + CpuW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign task_in.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign result_out.valid = (state == S_OUT);
  assign result_out.cpu_index = oi;
  assign result_out.cpu_busy = idle_res ? 1'b0 : ran[oi];
  assign result_out.task_slot = idle_res ? '0 : ran_slot[oi];
  assign result_out.task_left = idle_res ? '0 : ran_left[oi];
  assign result_out.tick_number = tnum;
  assign result_out.idle_ticks = idle_count;
  assign result_out.finished_count = done_count;
  assign result_out.all_done = (done_count >= 5'(n_use)) && empty;
  assign result_out.coin_used = idle_res ? 1'b0 : (ran[oi] && coin_task[ran_slot[oi]]);
  assign result_out.last = (CpuCntW'(oi) + CpuCntW'(1) == m_use);

endmodule

// File: tb/mpts_checker.sv
module mpts_checker
  import mpts_pkg::*;
(
  input logic clk,
  input logic rst,
  mpts_in_if task_in,
  mpts_out_if result_out,
  mpts_cfg_if cfg,
  output int pending,
  output int failures,
  output int checked,
  output int ticks_now
);

  typedef struct packed {
    logic [2:0] cpu_index;
    logic cpu_busy;
    logic [3:0] task_slot;
    logic [15:0] task_left;
    logic [15:0] tick_number;
    logic [15:0] idle_ticks;
    logic [4:0] finished_count;
    logic all_done;
    logic coin_used;
    logic last;
  } cpu_word_t;

  cpu_word_t expected_words[$];

  int mode_reg, slice_reg, cpus_reg, aging_reg, tasks_reg;
  logic [1:0] phase[MaxTasks];
  int arrival[MaxTasks], burst[MaxTasks], remain[MaxTasks];
  int sprio[MaxTasks], dprio[MaxTasks], used[MaxTasks];
  int ready_q[$];
  int cpu_slot[MaxCpus];
  bit cpu_held[MaxCpus];
  int tick_cnt, idle_cnt, done_cnt;
  logic [15:0] lfsr;

  assign ticks_now = tick_cnt;

  function automatic int queue_find(int s);
    foreach (ready_q[k]) if (ready_q[k] == s) return k;
    return -1;
  endfunction

  function automatic void queue_push(int s);
    if (queue_find(s) < 0 && ready_q.size() < MaxTasks) ready_q = {ready_q, s};
  endfunction

  function automatic bit coin_draw();
    bit b;
    b = lfsr[0];
    lfsr = lfsr >> 1;
    if (b) lfsr = lfsr ^ LfsrMask;
    return b;
  endfunction

  function automatic int best_ready(bit srtf, output bit by_coin);
    int best, c, b;
    bit swap, tie, coin, ce, be;
    best = 0;
    by_coin = 0;
    for (int j = 1; j < ready_q.size(); j++) begin
      c = ready_q[j];
      b = ready_q[best];
      swap = 0;
      tie = 0;
      coin = 0;
      if (srtf) begin
        if (remain[c] < remain[b]) swap = 1;
        else if (remain[c] == remain[b]) tie = 1;
      end else begin
        if (dprio[c] > dprio[b]) swap = 1;
        else if (dprio[c] == dprio[b]) tie = 1;
      end
      if (tie) begin
        ce = phase[c] == PhRun;
        be = phase[b] == PhRun;
        if (ce && !be) swap = 1;
        if (ce || be) tie = 0;
      end
      if (tie) begin
        if (arrival[c] < arrival[b]) swap = 1;
        else if (arrival[c] == arrival[b]) begin
          if (burst[c] < burst[b]) swap = 1;
          else if (burst[c] == burst[b] && coin_draw()) begin
            swap = 1;
            coin = 1;
          end
        end
      end
      if (swap) begin
        best = j;
        by_coin = coin;
      end
    end
    return best;
  endfunction

  function automatic void load_entry(int s, int a, int b, int p);
    int k;
    k = queue_find(s);
    if (k >= 0) ready_q.delete(k);
    for (int i = 0; i < MaxCpus; i++) if (cpu_held[i] && cpu_slot[i] == s) cpu_held[i] = 0;
    phase[s] = PhNew;
    arrival[s] = a;
    burst[s] = b;
    remain[s] = b;
    sprio[s] = p;
    dprio[s] = p;
    used[s] = 0;
  endfunction

  function automatic void push_word(int i, int m, bit busy, int s, int left, int tnum,
                                    bit alldone, bit coin);
    cpu_word_t w;
    w.cpu_index = 3'(i);
    w.cpu_busy = busy;
    w.task_slot = 4'(s);
    w.task_left = 16'(left);
    w.tick_number = 16'(tnum);
    w.idle_ticks = 16'(idle_cnt);
    w.finished_count = 5'(done_cnt);
    w.all_done = alldone;
    w.coin_used = coin;
    w.last = (i + 1 == m);
    expected_words = {expected_words, w};
  endfunction

  function automatic void run_tick();
    int n, m, tnum, bi, b, worst, lim, v, ev, s;
    bit srtf, aging, empty, changed, by_coin, placed, on_cpu;
    bit coin_task[MaxTasks];
    bit expire[MaxCpus], ran[MaxCpus];
    int ran_slot[MaxCpus], ran_left[MaxCpus];
    n = tasks_reg > MaxTasks ? MaxTasks : tasks_reg;
    m = cpus_reg < 1 ? 1 : (cpus_reg > MaxCpus ? MaxCpus : cpus_reg);
    srtf = mode_reg == ModeSrtf;
    aging = mode_reg == ModeAging;
    tnum = tick_cnt;
    for (int i = m; i < MaxCpus; i++) begin
      if (cpu_held[i]) begin
        phase[cpu_slot[i]] = PhReady;
        queue_push(cpu_slot[i]);
        cpu_held[i] = 0;
      end
    end
    empty = 1;
    for (int i = 0; i < m; i++) if (cpu_held[i]) empty = 0;
    if (done_cnt >= n && empty) begin
      for (int i = 0; i < m; i++) push_word(i, m, 0, 0, 0, tnum, 1, 0);
      return;
    end
    foreach (coin_task[k]) coin_task[k] = 0;
    for (s = 0; s < n; s++) begin
      if (phase[s] == PhNew && arrival[s] == tick_cnt) begin
        phase[s] = PhReady;
        queue_push(s);
      end
    end
    for (int i = 0; i < m; i++) if (cpu_held[i]) queue_push(cpu_slot[i]);
    changed = 1;
    while (ready_q.size() > 0 && changed) begin
      bi = best_ready(srtf, by_coin);
      b = ready_q[bi];
      changed = 0;
      placed = 0;
      on_cpu = 0;
      if (by_coin) coin_task[b] = 1;
      for (int i = 0; i < m; i++) if (cpu_held[i] && cpu_slot[i] == b) on_cpu = 1;
      for (int i = 0; i < m && !placed; i++) begin
        if (!cpu_held[i]) begin
          if (!on_cpu) begin
            cpu_held[i] = 1;
            cpu_slot[i] = b;
            phase[b] = PhRun;
          end
          placed = 1;
        end else if (cpu_slot[i] == b) placed = 1;
      end
      if (placed) begin
        ready_q.delete(bi);
        changed = 1;
        continue;
      end
      worst = -1;
      lim = srtf ? remain[b] : dprio[b];
      for (int i = 0; i < m; i++) begin
        if (!cpu_held[i]) continue;
        v = srtf ? remain[cpu_slot[i]] : dprio[cpu_slot[i]];
        if (srtf ? (v > lim) : (v < lim)) begin
          lim = v;
          worst = i;
        end
      end
      if (worst >= 0) begin
        ev = cpu_slot[worst];
        phase[ev] = PhReady;
        ready_q.delete(bi);
        queue_push(ev);
        cpu_slot[worst] = b;
        phase[b] = PhRun;
        changed = 1;
      end
    end
    for (int i = 0; i < m; i++) begin
      expire[i] = 0;
      ran[i] = cpu_held[i];
      ran_slot[i] = 0;
      ran_left[i] = 0;
      if (cpu_held[i]) begin
        s = cpu_slot[i];
        if (remain[s] > 0) begin
          remain[s]--;
          if (used[s] < TimeMax) used[s]++;
        end
        if (slice_reg > 0 && used[s] >= slice_reg && remain[s] > 0) begin
          expire[i] = 1;
          used[s] = 0;
        end
        ran_slot[i] = s;
        ran_left[i] = remain[s];
      end else if (done_cnt < n && idle_cnt < TimeMax) idle_cnt++;
    end
    if (aging) begin
      foreach (ready_q[k]) begin
        v = dprio[ready_q[k]] + aging_reg;
        dprio[ready_q[k]] = v > PrioMax ? PrioMax : v;
      end
      for (int i = 0; i < m; i++) if (cpu_held[i]) dprio[cpu_slot[i]] = sprio[cpu_slot[i]];
    end
    for (int i = 0; i < m; i++) begin
      if (!cpu_held[i]) continue;
      s = cpu_slot[i];
      if (remain[s] == 0) begin
        if (phase[s] != PhDone && done_cnt < DoneMax) done_cnt++;
        phase[s] = PhDone;
        cpu_held[i] = 0;
      end else if (expire[i]) begin
        phase[s] = PhReady;
        queue_push(s);
        cpu_held[i] = 0;
      end
    end
    if (tick_cnt < TimeMax) tick_cnt++;
    empty = 1;
    for (int i = 0; i < m; i++) if (cpu_held[i]) empty = 0;
    for (int i = 0; i < m; i++)
      push_word(i, m, ran[i], ran_slot[i], ran_left[i], tnum, done_cnt >= n && empty,
                ran[i] && coin_task[ran_slot[i]]);
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      failures++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    cpu_word_t w;
    if (rst) begin
      mode_reg = 0;
      slice_reg = 0;
      cpus_reg = 1;
      aging_reg = 0;
      tasks_reg = 0;
      foreach (phase[k]) phase[k] = PhNew;
      ready_q.delete();
      foreach (cpu_held[k]) cpu_held[k] = 0;
      tick_cnt = 0;
      idle_cnt = 0;
      done_cnt = 0;
      lfsr = LfsrSeed;
      expected_words.delete();
      failures = 0;
      checked = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CfgMode: mode_reg = int'(cfg.data[1:0]);
          CfgSlice: slice_reg = int'(cfg.data);
          CfgCpus: cpus_reg = int'(cfg.data[3:0]);
          CfgAging: aging_reg = int'(cfg.data[7:0]);
          CfgTasks: tasks_reg = int'(cfg.data[4:0]);
          default: ;
        endcase
      end
      if (task_in.valid && task_in.ready) begin
        if (task_in.func == FuncTick) run_tick();
        else load_entry(int'(task_in.slot), int'(task_in.arrival_time),
                        int'(task_in.burst_length), int'(task_in.base_prio));
      end
      if (result_out.valid && result_out.ready) begin
        checked++;
        if (expected_words.size() == 0) begin
          failures++;
          $display("%0t: word from processor %0d with no word expected", $time,
                   result_out.cpu_index);
        end else begin
          w = expected_words.pop_front();
          check_field("cpu_index", w.cpu_index, result_out.cpu_index);
          check_field("cpu_busy", w.cpu_busy, result_out.cpu_busy);
          check_field("task_slot", w.task_slot, result_out.task_slot);
          check_field("task_left", w.task_left, result_out.task_left);
          check_field("tick_number", w.tick_number, result_out.tick_number);
          check_field("idle_ticks", w.idle_ticks, result_out.idle_ticks);
          check_field("finished_count", w.finished_count, result_out.finished_count);
          check_field("all_done", w.all_done, result_out.all_done);
          check_field("coin_used", w.coin_used, result_out.coin_used);
          check_field("last", w.last, result_out.last);
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// File: tb/tb_multicore_preemptive_task_scheduler.sv
module tb_multicore_preemptive_task_scheduler;
  import mpts_pkg::*;

  logic clk;
  logic rst;
  int pending, failures, checked, ticks_now;
  int items_sent;
  bit calm;
  bit long_hold;
  bit long_taken;
  int hold_left;

  mpts_in_if in_ch();
  mpts_out_if out_ch();
  mpts_cfg_if cfg_ch();

  multicore_preemptive_task_scheduler uut (
    .clk(clk),
    .rst(rst),
    .task_in(in_ch),
    .result_out(out_ch),
    .cfg(cfg_ch)
  );

  mpts_checker chk (
    .clk(clk),
    .rst(rst),
    .task_in(in_ch),
    .result_out(out_ch),
    .cfg(cfg_ch),
    .pending(pending),
    .failures(failures),
    .checked(checked),
    .ticks_now(ticks_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    hold_left = 0;
    long_taken = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (long_hold && !long_taken) begin
        long_taken = 1;
        hold_left = 400;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else out_ch.ready <= 1'b1;
    end
  end

  task automatic send_word(bit f, logic [3:0] s, logic [7:0] id, logic [15:0] a,
                           logic [15:0] b, logic [7:0] p);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.slot <= s;
    in_ch.task_number <= id;
    in_ch.arrival_time <= a;
    in_ch.burst_length <= b;
    in_ch.base_prio <= p;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic load_random(int s);
    logic [15:0] a, b;
    logic [7:0] p;
    a = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535)) :
        16'(ticks_now + $urandom_range(0, 8));
    b = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535)) :
        16'($urandom_range(1, 6));
    p = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
    send_word(FuncLoad, 4'(s), 8'($urandom_range(0, 255)), a, b, p);
  endtask

  initial begin
    int n, cpus, slice, age;
    rst = 1'b1;
    calm = 0;
    long_hold = 0;
    items_sent = 0;
    in_ch.valid = 1'b0;
    in_ch.func = FuncLoad;
    in_ch.slot = '0;
    in_ch.task_number = '0;
    in_ch.arrival_time = '0;
    in_ch.burst_length = 16'd1;
    in_ch.base_prio = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CfgMode;
    cfg_ch.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(CfgTasks, 16'd16);
    write_reg(CfgCpus, 16'd1);
    send_word(FuncLoad, 4'd15, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_word(FuncLoad, 4'd0, 8'h00, 16'd0, 16'd1, 8'd0);
    send_word(FuncLoad, 4'd1, 8'hAA, 16'd0, 16'hFFFF, 8'hFF);
    for (int s = 2; s < 15; s++) send_word(FuncLoad, 4'(s), 8'(s), 16'(s % 3), 16'd2, 8'd1);
    repeat (6) send_word(FuncTick, 4'd0, 8'd0, 16'd0, 16'd1, 8'd0);

    for (int p = 0; p < 11; p++) begin
      settle();
      if (p == 10) calm = 1;
      n = (p == 5) ? 0 : (p == 1 || p == 0) ? 16 : $urandom_range(1, 16);
      cpus = (p == 0) ? 1 : (p == 1) ? 8 : $urandom_range(1, 8);
      slice = (p == 2) ? 65535 : ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      age = (p == 4) ? 255 : $urandom_range(0, 40);
      write_reg(CfgMode, 16'(p % 3));
      write_reg(CfgSlice, 16'(slice));
      write_reg(CfgCpus, 16'(cpus));
      write_reg(CfgAging, 16'(age));
      write_reg(CfgTasks, 16'(n));
      for (int s = 0; s < n; s++) load_random(s);
      if (p == 3) long_hold = 1;
      for (int t = 0; t < 22; t++) begin
        if ($urandom_range(0, 9) == 0) load_random($urandom_range(0, 15));
        else send_word(FuncTick, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)),
                       8'($urandom_range(0, 255)));
      end
    end

    settle();
    repeat (200) @(posedge clk);
    $display("Ran %0d words through eleven register settings in all three modes;",
             items_sent);
    $display("%0d processor words were compared against the predicted schedule.", checked);
    if (failures == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: multicore_preemptive_task_scheduler.f
design/mpts_pkg.sv
design/mpts_if.sv
design/multicore_preemptive_task_scheduler.sv
tb/mpts_checker.sv
tb/tb_multicore_preemptive_task_scheduler.sv
